FILE: design/nwms_pkg.sv
// ----------------------------------------------------------------------------
// nwms_pkg
// Shared types, constants, microcode ROM and helpers for the number word
// multiplier stack.
// ----------------------------------------------------------------------------
`default_nettype none

package nwms_pkg;

  // Default parameter values
  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned VALUE_BITS_DEF  = 16;

  // Fixed port field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_VALUE_W = 16;
  localparam int unsigned EXP_W      = 6;
  localparam int unsigned INDEX_W    = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 6;

  localparam logic [EXP_W-1:0] EXP_MAX        = 6'd63;
  localparam logic [EXP_W-1:0] MAX_MULT_RESET = 6'd12;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 2'd0,
    CMD_SET_MULT = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_REJECT    = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  // Jump conditions of a control word
  typedef enum logic [3:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_START,
    COND_IDX_ZERO,
    COND_E_LT_M,
    COND_SUM_GE_E,
    COND_SUM_GT_MAX,
    COND_IDX_EQ_FILL,
    COND_BAD_INDEX
  } cond_e;

  // Datapath actions of a control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_SCAN_INIT,
    ACT_RD_IDXM1,
    ACT_EVAL,
    ACT_RD_IDX,
    ACT_WR_EXP,
    ACT_REJECT,
    ACT_CLEAR,
    ACT_RD_INDEX,
    ACT_LOAD_READ,
    ACT_BAD_INDEX,
    ACT_EMIT
  } act_e;

  typedef logic [3:0] step_t;

  // Program addresses
  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_ADD      = 4'd1;
  localparam step_t STEP_S_INIT   = 4'd2;
  localparam step_t STEP_S_READ   = 4'd3;
  localparam step_t STEP_S_EVAL   = 4'd4;
  localparam step_t STEP_S_STOP   = 4'd5;
  localparam step_t STEP_S_FINAL  = 4'd6;
  localparam step_t STEP_A_READ   = 4'd7;
  localparam step_t STEP_A_WRITE  = 4'd8;
  localparam step_t STEP_REJECT   = 4'd9;
  localparam step_t STEP_CLEAR    = 4'd10;
  localparam step_t STEP_R_READ   = 4'd11;
  localparam step_t STEP_R_LOAD   = 4'd12;
  localparam step_t STEP_R_BAD    = 4'd13;
  localparam step_t STEP_DONE     = 4'd14;

  typedef struct packed {
    cond_e cond;
    step_t target;
    act_e  act;
    logic  accept;
  } ctrl_t;

  typedef struct packed {
    logic idx_zero;
    logic e_lt_m;
    logic sum_ge_e;
    logic sum_gt_max;
    logic idx_eq_fill;
    logic bad_index;
  } flags_t;

  // Microprogram: one control word per step
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    w = '{cond: COND_START, target: STEP_IDLE, act: ACT_NONE, accept: 1'b1};
    case (step)
      STEP_IDLE:    w = '{COND_START,       STEP_IDLE,    ACT_NONE,      1'b1};
      STEP_ADD:     w = '{COND_ALWAYS,      STEP_DONE,    ACT_PUSH,      1'b0};
      STEP_S_INIT:  w = '{COND_NEXT,        STEP_IDLE,    ACT_SCAN_INIT, 1'b0};
      STEP_S_READ:  w = '{COND_IDX_ZERO,    STEP_S_FINAL, ACT_RD_IDXM1,  1'b0};
      STEP_S_EVAL:  w = '{COND_E_LT_M,      STEP_S_READ,  ACT_EVAL,      1'b0};
      STEP_S_STOP:  w = '{COND_SUM_GE_E,    STEP_REJECT,  ACT_NONE,      1'b0};
      STEP_S_FINAL: w = '{COND_SUM_GT_MAX,  STEP_REJECT,  ACT_NONE,      1'b0};
      STEP_A_READ:  w = '{COND_IDX_EQ_FILL, STEP_DONE,    ACT_RD_IDX,    1'b0};
      STEP_A_WRITE: w = '{COND_ALWAYS,      STEP_A_READ,  ACT_WR_EXP,    1'b0};
      STEP_REJECT:  w = '{COND_ALWAYS,      STEP_DONE,    ACT_REJECT,    1'b0};
      STEP_CLEAR:   w = '{COND_ALWAYS,      STEP_DONE,    ACT_CLEAR,     1'b0};
      STEP_R_READ:  w = '{COND_BAD_INDEX,   STEP_R_BAD,   ACT_RD_INDEX,  1'b0};
      STEP_R_LOAD:  w = '{COND_ALWAYS,      STEP_DONE,    ACT_LOAD_READ, 1'b0};
      STEP_R_BAD:   w = '{COND_ALWAYS,      STEP_DONE,    ACT_BAD_INDEX, 1'b0};
      STEP_DONE:    w = '{COND_START,       STEP_IDLE,    ACT_EMIT,      1'b1};
      default:      w = '{COND_START,       STEP_IDLE,    ACT_NONE,      1'b1};
    endcase
    return w;
  endfunction

  // Entry point of each command's routine
  function automatic step_t dispatch(input logic [CMD_W-1:0] cmd);
    step_t s;
    s = STEP_IDLE;
    case (cmd_e'(cmd))
      CMD_ADD:      s = STEP_ADD;
      CMD_SET_MULT: s = STEP_S_INIT;
      CMD_CLEAR:    s = STEP_CLEAR;
      CMD_READ:     s = STEP_R_READ;
      default:      s = STEP_IDLE;
    endcase
    return s;
  endfunction

  // Exponent sum, held at the top of the range
  function automatic logic [EXP_W-1:0] sat_sum(input logic [EXP_W-1:0] a,
                                               input logic [EXP_W-1:0] b);
    logic [EXP_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[EXP_W] ? EXP_MAX : s[EXP_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/nwms_ram.sv
// ----------------------------------------------------------------------------
// nwms_ram
// Single-port RAM, one write and one read per cycle on a shared address, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nwms_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/nwms_useq.sv
// ----------------------------------------------------------------------------
// nwms_useq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module nwms_useq (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [nwms_pkg::CMD_W-1:0]   command_i,
  input  wire nwms_pkg::flags_t             flags_i,
  output nwms_pkg::ctrl_t                   ctrl_o
);

  nwms_pkg::step_t step_q, step_d;
  nwms_pkg::ctrl_t ctrl;
  logic            take;

  // Fetch the control word of the current step
  assign ctrl   = nwms_pkg::ucode_rom(step_q);
  assign ctrl_o = ctrl;

  // Pick the next step
  always_comb begin
    take = 1'b0;
    case (ctrl.cond)
      nwms_pkg::COND_NEXT:        take = 1'b0;
      nwms_pkg::COND_ALWAYS:      take = 1'b1;
      nwms_pkg::COND_START:       take = 1'b1;
      nwms_pkg::COND_IDX_ZERO:    take = flags_i.idx_zero;
      nwms_pkg::COND_E_LT_M:      take = flags_i.e_lt_m;
      nwms_pkg::COND_SUM_GE_E:    take = flags_i.sum_ge_e;
      nwms_pkg::COND_SUM_GT_MAX:  take = flags_i.sum_gt_max;
      nwms_pkg::COND_IDX_EQ_FILL: take = flags_i.idx_eq_fill;
      nwms_pkg::COND_BAD_INDEX:   take = flags_i.bad_index;
      default:                    take = 1'b0;
    endcase

    if (ctrl.cond == nwms_pkg::COND_START && start_i) begin
      step_d = nwms_pkg::dispatch(command_i);
    end else if (take) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= nwms_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/nwms_datapath.sv
// ----------------------------------------------------------------------------
// nwms_datapath
// Token store, scan registers and result registers, driven by control words.
// ----------------------------------------------------------------------------
`default_nettype none

module nwms_datapath #(
  parameter int unsigned STACK_DEPTH = nwms_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = nwms_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire nwms_pkg::ctrl_t                   ctrl_i,
  input  wire logic                              accept_i,
  input  wire logic [nwms_pkg::IN_VALUE_W-1:0]   token_value_i,
  input  wire logic [nwms_pkg::EXP_W-1:0]        multiplier_i,
  input  wire logic [nwms_pkg::INDEX_W-1:0]      read_index_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic [nwms_pkg::EXP_W-1:0]        cfg_data_i,
  output nwms_pkg::flags_t                       flags_o,
  output logic      [nwms_pkg::STATUS_W-1:0]     status_o,
  output logic      [nwms_pkg::COUNT_W-1:0]      token_count_o,
  output logic                                   is_empty_o,
  output logic      [nwms_pkg::IN_VALUE_W-1:0]   read_value_o,
  output logic      [nwms_pkg::EXP_W-1:0]        read_multiplier_o
);

  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > nwms_pkg::INDEX_W) ? CNT_W : nwms_pkg::INDEX_W;
  localparam int unsigned OCNT_W = (CNT_W > nwms_pkg::COUNT_W) ? CNT_W : nwms_pkg::COUNT_W;
  localparam int unsigned VAL_XW = (VALUE_BITS > nwms_pkg::IN_VALUE_W) ?
                                   VALUE_BITS : nwms_pkg::IN_VALUE_W;

  // Latched item fields
  logic [nwms_pkg::IN_VALUE_W-1:0] value_q;
  logic [nwms_pkg::EXP_W-1:0]      mult_q;
  logic [nwms_pkg::INDEX_W-1:0]    rindex_q;

  // Control and scan state
  logic [CNT_W-1:0]           fill_q;
  logic [CNT_W-1:0]           idx_q;
  logic [CNT_W-1:0]           idx_m1;
  logic [nwms_pkg::EXP_W-1:0] last_sum_q;
  logic [nwms_pkg::EXP_W-1:0] max_q;

  // Result registers
  nwms_pkg::status_e               status_q;
  logic [nwms_pkg::IN_VALUE_W-1:0] rd_value_q;
  logic [nwms_pkg::EXP_W-1:0]      rd_exp_q;

  // Memory ports
  logic                       val_we, exp_we, mem_re;
  logic [ADDR_W-1:0]          addr;
  logic [VALUE_BITS-1:0]      val_wdata, val_rdata;
  logic [nwms_pkg::EXP_W-1:0] exp_wdata, exp_rdata;
  logic [VAL_XW-1:0]          val_in_x, val_out_x;
  logic [CMP_W-1:0]           rindex_x, fill_x;
  logic [OCNT_W-1:0]          fill_ox;
  logic                       full;

  assign idx_m1   = idx_q - 1'b1;
  assign full     = (fill_q == CNT_W'(STACK_DEPTH));
  assign rindex_x = CMP_W'(rindex_q);
  assign fill_x   = CMP_W'(fill_q);
  assign val_in_x  = VAL_XW'(value_q);
  assign val_wdata = val_in_x[VALUE_BITS-1:0];
  assign val_out_x = VAL_XW'(val_rdata);

  // Condition flags for the sequencer
  assign flags_o.idx_zero    = (idx_q == '0);
  assign flags_o.e_lt_m      = (exp_rdata < mult_q);
  assign flags_o.sum_ge_e    = (last_sum_q >= exp_rdata);
  assign flags_o.sum_gt_max  = (last_sum_q > max_q);
  assign flags_o.idx_eq_fill = (idx_q == fill_q);
  assign flags_o.bad_index   = !(rindex_x < fill_x);

  // Memory address and strobes
  always_comb begin
    val_we    = 1'b0;
    exp_we    = 1'b0;
    mem_re    = 1'b0;
    addr      = idx_q[ADDR_W-1:0];
    exp_wdata = nwms_pkg::sat_sum(exp_rdata, mult_q);
    case (ctrl_i.act)
      nwms_pkg::ACT_PUSH: begin
        addr      = fill_q[ADDR_W-1:0];
        val_we    = !full;
        exp_we    = !full;
        exp_wdata = '0;
      end
      nwms_pkg::ACT_RD_IDXM1: begin
        addr   = idx_m1[ADDR_W-1:0];
        mem_re = !flags_o.idx_zero;
      end
      nwms_pkg::ACT_RD_IDX: begin
        mem_re = !flags_o.idx_eq_fill;
      end
      nwms_pkg::ACT_WR_EXP: begin
        exp_we = 1'b1;
      end
      nwms_pkg::ACT_RD_INDEX: begin
        addr   = rindex_x[ADDR_W-1:0];
        mem_re = !flags_o.bad_index;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  nwms_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_values (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .re_i    (mem_re),
    .addr_i  (addr),
    .wdata_i (val_wdata),
    .rdata_o (val_rdata)
  );

  nwms_ram #(
    .WIDTH (nwms_pkg::EXP_W),
    .DEPTH (STACK_DEPTH)
  ) u_exps (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .re_i    (mem_re),
    .addr_i  (addr),
    .wdata_i (exp_wdata),
    .rdata_o (exp_rdata)
  );

  // Latch item fields on acceptance
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      value_q  <= token_value_i;
      mult_q   <= multiplier_i;
      rindex_q <= read_index_i;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= nwms_pkg::MAX_MULT_RESET;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl_i.act == nwms_pkg::ACT_PUSH && !full) begin
      fill_q <= fill_q + 1'b1;
    end else if (ctrl_i.act == nwms_pkg::ACT_CLEAR) begin
      fill_q <= '0;
    end
  end

  // Scan pointer and last sum
  always_ff @(posedge clk_i) begin
    case (ctrl_i.act)
      nwms_pkg::ACT_SCAN_INIT: begin
        idx_q      <= fill_q;
        last_sum_q <= '0;
      end
      nwms_pkg::ACT_EVAL: begin
        if (flags_o.e_lt_m) begin
          idx_q      <= idx_m1;
          last_sum_q <= nwms_pkg::sat_sum(exp_rdata, mult_q);
        end
      end
      nwms_pkg::ACT_WR_EXP: begin
        idx_q <= idx_q + 1'b1;
      end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

  // Result registers: cleared on acceptance, set by the routine
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      status_q   <= nwms_pkg::ST_OK;
      rd_value_q <= '0;
      rd_exp_q   <= '0;
    end else begin
      case (ctrl_i.act)
        nwms_pkg::ACT_PUSH: begin
          if (full) begin
            status_q <= nwms_pkg::ST_FULL;
          end
        end
        nwms_pkg::ACT_REJECT: begin
          status_q <= nwms_pkg::ST_REJECT;
        end
        nwms_pkg::ACT_BAD_INDEX: begin
          status_q <= nwms_pkg::ST_BAD_INDEX;
        end
        nwms_pkg::ACT_LOAD_READ: begin
          rd_value_q <= val_out_x[nwms_pkg::IN_VALUE_W-1:0];
          rd_exp_q   <= exp_rdata;
        end
        default: begin
          status_q <= status_q;
        end
      endcase
    end
  end

  // Drive result ports
  assign fill_ox           = OCNT_W'(fill_q);
  assign status_o          = status_q;
  assign token_count_o     = fill_ox[nwms_pkg::COUNT_W-1:0];
  assign is_empty_o        = (fill_q == '0);
  assign read_value_o      = rd_value_q;
  assign read_multiplier_o = rd_exp_q;

endmodule

`default_nettype wire

FILE: design/number_word_multiplier_stack_core.sv
// ----------------------------------------------------------------------------
// number_word_multiplier_stack_core
// Stack of number tokens with multiplier exponents, run by a microcoded
// sequencer over a single-port token store.
// ----------------------------------------------------------------------------
// Set multiplier scans the trailing tokens above a stopping token, or down to
// the oldest token; a reject ends after the check pass.
// One item at a time; a new item may be started in the done_o cycle.
// Results cannot be stalled. Reset empties the stack and sets max_multiplier to 12.
`default_nettype none

module number_word_multiplier_stack_core #(
  parameter int unsigned STACK_DEPTH = nwms_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = nwms_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [nwms_pkg::CMD_W-1:0]        command_i,
  input  wire logic [nwms_pkg::IN_VALUE_W-1:0]   token_value_i,
  input  wire logic [nwms_pkg::EXP_W-1:0]        multiplier_i,
  input  wire logic [nwms_pkg::INDEX_W-1:0]      read_index_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [nwms_pkg::EXP_W-1:0]        cfg_data_i,
  output logic                                   done_o,
  output logic      [nwms_pkg::STATUS_W-1:0]     status_o,
  output logic      [nwms_pkg::COUNT_W-1:0]      token_count_o,
  output logic                                   is_empty_o,
  output logic      [nwms_pkg::IN_VALUE_W-1:0]   read_value_o,
  output logic      [nwms_pkg::EXP_W-1:0]        read_multiplier_o
);

  nwms_pkg::ctrl_t  ctrl;
  nwms_pkg::flags_t flags;
  logic             accept;

  // Handshake
  assign busy        = !ctrl.accept;
  assign accept      = start && ctrl.accept;
  assign cfg_ready_o = 1'b1;
  assign done_o      = (ctrl.act == nwms_pkg::ACT_EMIT);

  nwms_useq u_useq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .flags_i   (flags),
    .ctrl_o    (ctrl)
  );

  nwms_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .accept_i          (accept),
    .token_value_i     (token_value_i),
    .multiplier_i      (multiplier_i),
    .read_index_i      (read_index_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .flags_o           (flags),
    .status_o          (status_o),
    .token_count_o     (token_count_o),
    .is_empty_o        (is_empty_o),
    .read_value_o      (read_value_o),
    .read_multiplier_o (read_multiplier_o)
  );

endmodule

`default_nettype wire
